/* rtl/mstt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstt_pkg: shared definitions for the periodic task timer
// Widths, opcodes, result kinds and sequencer states used by the channels
// and by the timer core.
// ----------------------------------------------------------------------------
package mstt_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int FUNC_W    = 3;
  localparam int SLOTF_W   = 3;
  localparam int RATE_W    = 16;
  localparam int FRAMES_W  = 16;
  localparam int KIND_W    = 2;
  localparam int FIRE_W    = 30;
  localparam int SR_W      = 18;
  localparam int PER_W     = 30;
  localparam int ACC_W     = 48;
  localparam int PROD_W    = FRAMES_W + PER_W;
  localparam int CNT_W     = $clog2(ACC_W);

  localparam logic [PER_W-1:0]  NS_PER_SEC = 30'd1000000000;
  localparam logic [FIRE_W-1:0] FIRE_MAX   = {FIRE_W{1'b1}};
  localparam logic [SR_W-1:0]   SR_RESET   = 18'd48000;

  typedef enum logic [FUNC_W-1:0] {
    FN_SCHEDULE  = 3'd0,
    FN_TERMINATE = 3'd1,
    FN_SET_RATE  = 3'd2,
    FN_ADVANCE   = 3'd3,
    FN_SHUTDOWN  = 3'd4
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KD_GRANT   = 2'd0,
    KD_NO_FREE = 2'd1,
    KD_ACK     = 2'd2,
    KD_FIRE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE,
    ST_WALK,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_PERIOD,
    DV_ELAPSED,
    DV_FIRE
  } div_op_t;

endpackage
`default_nettype wire

/* rtl/mstt_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstt_if: valid/ready channels of the periodic task timer
// Request channel, result channel and sample rate write channel.
// ----------------------------------------------------------------------------
interface mstt_req_if;
  import mstt_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SLOTF_W-1:0]  slot;
  logic [RATE_W-1:0]   rate_hz;
  logic [FRAMES_W-1:0] frames;

  modport source (output valid, func, slot, rate_hz, frames, input ready);
  modport sink   (input valid, func, slot, rate_hz, frames, output ready);
endinterface

interface mstt_res_if;
  import mstt_pkg::*;
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [SLOTF_W-1:0] slot_out;
  logic [FIRE_W-1:0]  fire_count;
  logic               last;

  modport source (output valid, kind, slot_out, fire_count, last, input ready);
  modport sink   (input valid, kind, slot_out, fire_count, last, output ready);
endinterface

interface mstt_cfg_if;
  import mstt_pkg::*;
  logic            valid;
  logic            ready;
  logic [SR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/multi_slot_periodic_task_timer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_periodic_task_timer: table of periodic task slots
// Schedules, retimes and retires task slots, and on each advance converts
// rendered audio frames to nanoseconds and reports how often each busy slot
// fired. All divisions run on one shared restoring divider.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  -------------------------------------------
//  req      in   valid/ready    func, slot, rate_hz, frames
//  res      out  valid/ready    kind, slot_out, fire_count, last
//  cfg      in   valid/ready    data (sample_rate, always ready)
//
//  The divider retires one quotient bit per cycle, 48 bits per division.
//  Set rate and a schedule with a free slot run one division; other codes
//  skip the divider. Advance runs one division plus one per busy slot and
//  skips free slots. One request is in flight at a time.
//  Reset frees all slots and loads sample_rate with 48000; no clearing pass.
//  A result held in the output register stalls the sequencer until taken.
// ----------------------------------------------------------------------------
module multi_slot_periodic_task_timer
  import mstt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  mstt_req_if.sink    req,
  mstt_res_if.source  res,
  mstt_cfg_if.sink    cfg
);

  // sequencer
  state_t state, state_next;

  // configuration
  logic [SR_W-1:0] sample_rate;

  // slot table
  logic [NUM_SLOTS-1:0] busy;
  logic [PER_W-1:0]     period [NUM_SLOTS];
  logic [ACC_W-1:0]     accum  [NUM_SLOTS];

  // latched request
  func_t               func_q;
  logic [FRAMES_W-1:0] frames_q;
  logic [SLOT_W-1:0]   tgt;
  logic                tgt_ok;

  // walk state
  logic [SLOT_W-1:0] idx;
  logic [ACC_W-1:0]  elapsed;

  // shared divider
  div_op_t          div_op;
  logic [ACC_W-1:0] div_quo;
  logic [PER_W-1:0] div_rem;
  logic [PER_W-1:0] div_den;
  logic [CNT_W-1:0] div_cnt;
  logic [PER_W:0]   div_shift;
  logic [PER_W+1:0] div_diff;
  logic             div_fits;

  // staged result and output register
  kind_t              pend_kind;
  logic [SLOTF_W-1:0] pend_slot;
  logic [FIRE_W-1:0]  pend_count;
  logic               pend_last;
  logic               res_valid;
  kind_t              res_kind;
  logic [SLOTF_W-1:0] res_slot;
  logic [FIRE_W-1:0]  res_count;
  logic               res_last;

  // helpers
  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              free_any;
  logic [SLOT_W-1:0] free_idx;
  logic              busy_above;
  logic              slot_in_range;
  logic [PROD_W-1:0] prod;
  func_t             func_in;

  assign func_in       = func_t'(req.func);
  assign req.ready     = (state == ST_IDLE);
  assign accept        = req.valid && req.ready;
  assign out_free      = !res_valid || res.ready;
  assign slot_in_range = (32'(req.slot) < NUM_SLOTS);
  assign free_any      = ~&busy;
  assign cfg.ready     = 1'b1;

  assign res.valid      = res_valid;
  assign res.kind       = res_kind;
  assign res.slot_out   = res_slot;
  assign res.fire_count = res_count;
  assign res.last       = res_last;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (!busy[j]) free_idx = SLOT_W'(j);
    end
  end

  // any busy slot after the one being walked
  always_comb begin
    busy_above = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if ((SLOT_W'(j) > idx) && busy[j]) busy_above = 1'b1;
    end
  end

  // one restoring step: shift in the next dividend bit, try the subtract
  assign div_shift = {div_rem, div_quo[ACC_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, div_den};
  assign div_fits  = !div_diff[PER_W+1];

  // frames to nanoseconds, registered into the divider
  assign prod = PROD_W'(frames_q) * PROD_W'(NS_PER_SEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_in)
            FN_SCHEDULE: state_next = free_any ? ST_DIV : ST_OUT;
            FN_SET_RATE: state_next = ST_DIV;
            FN_ADVANCE:  state_next = ST_MUL;
            default:     state_next = ST_OUT;
          endcase
        end
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (div_op == DV_ELAPSED && busy != '0) state_next = ST_WALK;
        else state_next = ST_OUT;
      end
      ST_WALK: begin
        if (busy[idx]) state_next = ST_DIV;
      end
      ST_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = pend_last ? ST_IDLE : ST_WALK;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SR_RESET;
      busy        <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) sample_rate <= cfg.data;
      if (load_out) res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
      if (state == ST_IDLE && accept) begin
        if (func_in == FN_TERMINATE && slot_in_range) busy[SLOT_W'(req.slot)] <= 1'b0;
        if (func_in == FN_SHUTDOWN) busy <= '0;
      end
      if (state == ST_DONE && div_op == DV_PERIOD && func_q == FN_SCHEDULE) begin
        busy[tgt] <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          // latch the request and preload the period division
          func_q   <= func_in;
          frames_q <= req.frames;
          tgt      <= (func_in == FN_SCHEDULE) ? free_idx : SLOT_W'(req.slot);
          tgt_ok   <= (func_in == FN_SCHEDULE) || slot_in_range;
          div_op   <= DV_PERIOD;
          div_quo  <= ACC_W'(NS_PER_SEC);
          div_den  <= (req.rate_hz == '0) ? PER_W'(1) : PER_W'(req.rate_hz);
          div_rem  <= '0;
          div_cnt  <= CNT_W'(ACC_W - 1);
          // default single-result answer
          pend_count <= '0;
          pend_last  <= 1'b1;
          if (func_in == FN_SCHEDULE) begin
            pend_kind <= KD_NO_FREE;
            pend_slot <= '0;
          end else if (func_in == FN_TERMINATE || func_in == FN_SET_RATE) begin
            pend_kind <= KD_ACK;
            pend_slot <= req.slot;
          end else begin
            pend_kind <= KD_ACK;
            pend_slot <= '0;
          end
        end
      end
      ST_MUL: begin
        div_op  <= DV_ELAPSED;
        div_quo <= ACC_W'(prod);
        div_den <= (sample_rate == '0) ? PER_W'(1) : PER_W'(sample_rate);
        div_rem <= '0;
        div_cnt <= CNT_W'(ACC_W - 1);
      end
      ST_DIV: begin
        div_rem <= div_fits ? div_diff[PER_W-1:0] : div_shift[PER_W-1:0];
        div_quo <= {div_quo[ACC_W-2:0], div_fits};
        div_cnt <= div_cnt - CNT_W'(1);
      end
      ST_DONE: begin
        unique case (div_op)
          DV_PERIOD: begin
            if (tgt_ok) period[tgt] <= div_quo[PER_W-1:0];
            if (func_q == FN_SCHEDULE) begin
              accum[tgt] <= '0;
              pend_kind  <= KD_GRANT;
              pend_slot  <= SLOTF_W'(tgt);
            end
          end
          DV_ELAPSED: begin
            elapsed <= div_quo;
            idx     <= '0;
          end
          DV_FIRE: begin
            // keep the remainder, report the saturated quotient
            accum[idx] <= ACC_W'(div_rem);
            pend_kind  <= KD_FIRE;
            pend_slot  <= SLOTF_W'(idx);
            pend_count <= (|div_quo[ACC_W-1:FIRE_W]) ? FIRE_MAX : div_quo[FIRE_W-1:0];
            pend_last  <= !busy_above;
          end
          default: begin
          end
        endcase
      end
      ST_WALK: begin
        if (busy[idx]) begin
          div_op  <= DV_FIRE;
          div_quo <= accum[idx] + elapsed;
          div_den <= (period[idx] == '0) ? PER_W'(1) : period[idx];
          div_rem <= '0;
          div_cnt <= CNT_W'(ACC_W - 1);
        end else begin
          idx <= idx + SLOT_W'(1);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          res_kind  <= pend_kind;
          res_slot  <= pend_slot;
          res_count <= pend_count;
          res_last  <= pend_last;
          if (!pend_last) idx <= idx + SLOT_W'(1);
        end
      end
    endcase
  end

endmodule
`default_nettype wire
